>>> sv/jape_pkg.sv
// ----------------------------------------------------------------------------
// jape_pkg
// Shared types and constants of the joint angle population encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jape_pkg;

    // Q3.12 angle constants
    localparam int unsigned PI_Q12    = 12868;
    localparam int unsigned TWOPI_Q12 = 25736;

    // Longest run of cells one item may produce
    localparam int unsigned RUN_LIMIT = 32;
    localparam int unsigned ROW_LIMIT = RUN_LIMIT / 2;

    // Cell counts (up to RUN_LIMIT) and derived widths
    localparam int unsigned N_W    = 6;
    localparam int unsigned ACC_W  = 24;
    localparam int unsigned MAG_W  = 23;
    localparam int unsigned DEN_W  = 28;
    localparam int unsigned AMP_W  = 9;
    localparam int unsigned EXP_W  = 17;

    // Linear amplitude and response saturation
    localparam int unsigned LIN_AMP   = 256;
    localparam int unsigned CELL_MAX  = 255;

    // Configuration register indexes
    localparam logic [1:0] REG_UNITS_IN_USE = 2'd0;
    localparam logic [1:0] REG_WIDTH_FACTOR = 2'd1;

    // Resolved item, handed from the front end to the cell engine
    typedef struct packed {
        logic                    univ;   // universal joint reading
        logic [N_W-1:0]          n;      // cells per row
        logic [DEN_W-1:0]        den;    // spread times width factor
        logic [AMP_W-1:0]        amp;    // response amplitude, 0..256
        logic signed [ACC_W-1:0] a;      // linear base offset, or first direction times n
        logic signed [ACC_W-1:0] b;      // linear cell stride, or second direction times n
    } jape_desc_t;

endpackage

`default_nettype wire

>>> sv/jape_queue.sv
// ----------------------------------------------------------------------------
// jape_queue
// Two-entry queue of resolved items between front end and cell engine.
// ----------------------------------------------------------------------------
`default_nettype none

module jape_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire jape_pkg::jape_desc_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output jape_pkg::jape_desc_t     pop_data,
    output logic                     empty
);

    jape_pkg::jape_desc_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/jape_front.sv
// ----------------------------------------------------------------------------
// jape_front
// Accept an item, resolve its cell count, spread and amplitude, queue it.
// ----------------------------------------------------------------------------
`default_nettype none

module jape_front #(
    parameter int unsigned MAX_UNITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [4:0]           units_in_use,
    input  wire logic [11:0]          width_factor,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 op,
    input  wire logic signed [15:0]   joint_angle,
    input  wire logic signed [15:0]   range_low,
    input  wire logic signed [15:0]   range_high,
    input  wire logic signed [15:0]   delta_x,
    input  wire logic signed [15:0]   delta_y,
    input  wire logic signed [14:0]   abs_direction,
    input  wire logic signed [14:0]   change_direction,
    output logic                      push,
    output jape_pkg::jape_desc_t      push_data,
    input  wire logic                 full
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_CALC = 5'b00010,
        F_SQRT = 5'b00100,
        F_DIV  = 5'b01000,
        F_PUSH = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    // latched item
    logic                              op_reg;
    logic signed [15:0]                ang_reg, lo_reg, hi_reg, dx_reg, dy_reg;
    logic signed [14:0]                dir0_reg, dir1_reg;
    logic [jape_pkg::N_W-1:0]          n_reg;

    // square root and amplitude division
    logic [31:0]                       sv_reg, sv_next;
    logic [31:0]                       sr_reg, sr_next;
    logic [31:0]                       sbit_reg, sbit_next;
    logic [16:0]                       max_amp_reg, max_amp_next;
    logic [16:0]                       divisor_reg, divisor_next;
    logic [17:0]                       rem_reg, rem_next;
    logic [jape_pkg::AMP_W-1:0]        q_reg, q_next;
    logic [3:0]                        cnt_reg, cnt_next;
    jape_pkg::jape_desc_t              desc_reg, desc_next;

    // item resolution
    logic [jape_pkg::N_W-1:0]          n_clamp;
    logic signed [16:0]                spread, lo_off;
    logic [16:0]                       spread_mag;
    logic signed [6:0]                 n_s, nm1_s;
    logic signed [jape_pkg::ACC_W-1:0] base, dirn0, dirn1;
    logic signed [31:0]                dxsq, dysq;
    logic [32:0]                       s_sum;
    logic [16:0]                       ampl;
    logic [18:0]                       rem_sh;

    assign in_ready  = (state_reg == F_IDLE);
    assign push      = (state_reg == F_PUSH);
    assign push_data = desc_reg;

    always_comb begin
        if (units_in_use < 5'd2) begin
            n_clamp = jape_pkg::N_W'(2);
        end else if ({1'b0, units_in_use} > jape_pkg::N_W'(MAX_UNITS)) begin
            n_clamp = jape_pkg::N_W'(MAX_UNITS);
        end else begin
            n_clamp = {1'b0, units_in_use};
        end
        if (op && n_clamp > jape_pkg::N_W'(jape_pkg::ROW_LIMIT)) begin
            n_clamp = jape_pkg::N_W'(jape_pkg::ROW_LIMIT);
        end
    end

    always_comb begin
        spread     = {hi_reg[15], hi_reg} - {lo_reg[15], lo_reg};
        lo_off     = {lo_reg[15], lo_reg} - {ang_reg[15], ang_reg};
        spread_mag = spread[16] ? 17'(-spread) : 17'(spread);
        n_s        = {1'b0, n_reg};
        nm1_s      = n_s - 7'sd1;
        base       = nm1_s * lo_off;
        dirn0      = n_s * dir0_reg;
        dirn1      = n_s * dir1_reg;
        dxsq       = dx_reg * dx_reg;
        dysq       = dy_reg * dy_reg;
        s_sum      = {1'b0, sr_reg} + {1'b0, sbit_reg};
        ampl       = 17'(sr_next);
        rem_sh     = {rem_reg, 1'b0};
    end

    always_comb begin
        state_next   = state_reg;
        sv_next      = sv_reg;
        sr_next      = sr_reg;
        sbit_next    = sbit_reg;
        max_amp_next = max_amp_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        desc_next    = desc_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    state_next = F_CALC;
                end
            end
            F_CALC: begin
                desc_next.univ = op_reg;
                desc_next.n    = n_reg;
                if (op_reg) begin
                    desc_next.den = jape_pkg::DEN_W'(width_factor * jape_pkg::TWOPI_Q12);
                    desc_next.a   = dirn0;
                    desc_next.b   = dirn1;
                    sv_next       = 32'(dxsq) + 32'(dysq);
                    sr_next       = 32'd0;
                    sbit_next     = 32'h4000_0000;
                    state_next    = F_SQRT;
                end else begin
                    desc_next.den = jape_pkg::DEN_W'(spread_mag * width_factor);
                    desc_next.amp = jape_pkg::AMP_W'(jape_pkg::LIN_AMP);
                    desc_next.a   = base;
                    desc_next.b   = jape_pkg::ACC_W'(spread);
                    state_next    = F_PUSH;
                end
            end
            F_SQRT: begin
                // one result bit per step, digit by digit
                if ({1'b0, sv_reg} >= s_sum) begin
                    sv_next = 32'({1'b0, sv_reg} - s_sum);
                    sr_next = (sr_reg >> 1) + sbit_reg;
                end else begin
                    sr_next = sr_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
                if (sbit_reg[0]) begin
                    if (ampl > max_amp_reg) begin
                        max_amp_next = ampl;
                        divisor_next = ampl;
                    end else begin
                        divisor_next = max_amp_reg;
                    end
                    rem_next = {2'b00, ampl[16:1]};
                    q_next   = '0;
                    cnt_next = '0;
                    if (ampl == 17'd0) begin
                        desc_next.amp = '0;
                        state_next    = F_PUSH;
                    end else begin
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV: begin
                // amplitude over largest amplitude, 256 times ampl, quotient below 512
                if ({rem_sh[17:1], (cnt_reg == 4'd0) ? sr_reg[0] : 1'b0}
                        >= {1'b0, divisor_reg}) begin
                    rem_next = 18'({rem_sh[17:1], (cnt_reg == 4'd0) ? sr_reg[0] : 1'b0}
                        - {1'b0, divisor_reg});
                    q_next   = {q_reg[jape_pkg::AMP_W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_sh[17:1], (cnt_reg == 4'd0) ? sr_reg[0] : 1'b0};
                    q_next   = {q_reg[jape_pkg::AMP_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(jape_pkg::AMP_W - 1)) begin
                    desc_next.amp = q_next;
                    state_next    = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && in_valid) begin
            op_reg   <= op;
            ang_reg  <= joint_angle;
            lo_reg   <= range_low;
            hi_reg   <= range_high;
            dx_reg   <= delta_x;
            dy_reg   <= delta_y;
            dir0_reg <= abs_direction;
            dir1_reg <= change_direction;
            n_reg    <= n_clamp;
        end
        sv_reg      <= sv_next;
        sr_reg      <= sr_next;
        sbit_reg    <= sbit_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        cnt_reg     <= cnt_next;
        desc_reg    <= desc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            max_amp_reg <= '0;
        end else begin
            state_reg   <= state_next;
            max_amp_reg <= max_amp_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/jape_back.sv
// ----------------------------------------------------------------------------
// jape_back
// Cell engine: walk the cells of a queued item, one Gaussian response each.
// ----------------------------------------------------------------------------
`default_nettype none

module jape_back #(
    parameter int unsigned EXP_TABLE_DEPTH = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                empty,
    input  wire jape_pkg::jape_desc_t pop_data,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               cell_value,
    output logic [4:0]               cell_index,
    output logic                     last
);

    localparam int unsigned IDX_W    = $clog2(EXP_TABLE_DEPTH);
    localparam logic [63:0] EXP_STEP = (64'd8 << 32) / EXP_TABLE_DEPTH;
    localparam int unsigned Q_W      = 15;
    localparam logic [Q_W-1:0] Q_FAR = Q_W'(3 << 12);
    localparam int unsigned REM_W    = jape_pkg::DEN_W + 1;

    typedef logic [jape_pkg::EXP_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

    // exp(-i*8/depth) in Q16, stepped by a truncated Taylor series in Q32
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t           rom;
        logic [63:0]        term;
        logic [63:0]        e;
        logic [63:0]        r;
        logic signed [63:0] sum;
        term = 64'd1 << 32;
        sum  = $signed(term);
        for (int k = 1; k <= 16; k++) begin
            term = ((term * EXP_STEP) >> 32) / 64'(k);
            if (k[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        r = $unsigned(sum);
        e = 64'd1 << 32;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            rom[i] = jape_pkg::EXP_W'(e >> 16);
            e      = (e * r) >> 32;
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_LOAD  = 9'b000000010,
        B_START = 9'b000000100,
        B_DIV   = 9'b000001000,
        B_SQ    = 9'b000010000,
        B_IDX   = 9'b000100000,
        B_ROM   = 9'b001000000,
        B_MUL   = 9'b010000000,
        B_OUT   = 9'b100000000
    } back_state_t;

    back_state_t state_reg, state_next;

    jape_pkg::jape_desc_t              desc_reg, desc_next;
    logic signed [jape_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [jape_pkg::N_W-1:0]          pos_reg, pos_next;
    logic [jape_pkg::N_W-1:0]          col_reg, col_next;
    logic                              row_reg, row_next;
    logic [REM_W-1:0]                  rem_reg, rem_next;
    logic [Q_W-1:0]                    q_reg, q_next;
    logic [3:0]                        cnt_reg, cnt_next;
    logic [27:0]                       qsq_reg, qsq_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [jape_pkg::EXP_W-1:0]        e_reg, e_next;
    logic [7:0]                        value_reg, value_next;
    logic                              last_reg, last_next;

    logic [jape_pkg::N_W-1:0]          total;
    logic signed [jape_pkg::ACC_W-1:0] pin, twopin, centre0, dirn;
    logic signed [jape_pkg::ACC_W:0]   diff, dmag, dwrap;
    logic [jape_pkg::MAG_W-1:0]        mag;
    logic [REM_W-1:0]                  rem_sh;
    logic [40:0]                       idx_full;
    logic [25:0]                       amp_prod;

    assign pop        = (state_reg == B_IDLE) && !empty;
    assign out_valid  = (state_reg == B_OUT);
    assign cell_value = value_reg;
    assign cell_index = pos_reg[4:0];
    assign last       = last_reg;

    always_comb begin
        total   = desc_reg.univ ? jape_pkg::N_W'({desc_reg.n, 1'b0}) : desc_reg.n;
        pin     = jape_pkg::ACC_W'(desc_reg.n * jape_pkg::PI_Q12);
        twopin  = jape_pkg::ACC_W'(desc_reg.n * jape_pkg::TWOPI_Q12);
        centre0 = jape_pkg::ACC_W'(jape_pkg::PI_Q12) - pin;
        dirn    = row_reg ? desc_reg.b : desc_reg.a;
        // circular distance with one wrap
        diff    = {acc_reg[jape_pkg::ACC_W-1], acc_reg} - {dirn[jape_pkg::ACC_W-1], dirn};
        dmag    = diff[jape_pkg::ACC_W] ? -diff : diff;
        dwrap   = (dmag > {1'b0, pin}) ? ({1'b0, twopin} - dmag) : dmag;
        if (desc_reg.univ) begin
            mag = dwrap[jape_pkg::ACC_W] ? jape_pkg::MAG_W'(-dwrap)
                                         : jape_pkg::MAG_W'(dwrap);
        end else begin
            mag = acc_reg[jape_pkg::ACC_W-1] ? jape_pkg::MAG_W'(-acc_reg)
                                             : jape_pkg::MAG_W'(acc_reg);
        end
        rem_sh   = {rem_reg[REM_W-2:0], 1'b0};
        idx_full = 41'(qsq_reg) * 41'(EXP_TABLE_DEPTH);
        amp_prod = desc_reg.amp * e_reg;
    end

    always_comb begin
        state_next = state_reg;
        desc_next  = desc_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        qsq_next   = qsq_reg;
        idx_next   = idx_reg;
        e_next     = e_reg;
        value_next = value_reg;
        last_next  = last_reg;
        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    desc_next  = pop_data;
                    state_next = B_LOAD;
                end
            end
            B_LOAD: begin
                pos_next   = '0;
                col_next   = '0;
                row_next   = 1'b0;
                acc_next   = desc_reg.univ ? centre0 : desc_reg.a;
                state_next = B_START;
            end
            B_START: begin
                rem_next = REM_W'({mag, 5'b00000});
                q_next   = '0;
                cnt_next = '0;
                if (desc_reg.den == '0) begin
                    e_next     = (mag == '0) ? jape_pkg::EXP_W'(65536) : '0;
                    state_next = B_MUL;
                end else if ({1'b0, mag, 5'b00000} >= REM_W'(desc_reg.den)) begin
                    e_next     = '0;
                    state_next = B_MUL;
                end else begin
                    state_next = B_DIV;
                end
            end
            B_DIV: begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= REM_W'(desc_reg.den)) begin
                    rem_next = rem_sh - REM_W'(desc_reg.den);
                    q_next   = {q_reg[Q_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[Q_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(Q_W - 1)) begin
                    state_next = B_SQ;
                end
            end
            B_SQ: begin
                if (q_reg >= Q_FAR) begin
                    e_next     = '0;
                    state_next = B_MUL;
                end else begin
                    qsq_next   = 28'(q_reg[13:0] * q_reg[13:0]);
                    state_next = B_IDX;
                end
            end
            B_IDX: begin
                if ((idx_full >> 27) >= 41'(EXP_TABLE_DEPTH)) begin
                    e_next     = '0;
                    state_next = B_MUL;
                end else begin
                    idx_next   = IDX_W'(idx_full >> 27);
                    state_next = B_ROM;
                end
            end
            B_ROM: begin
                state_next = B_MUL;
            end
            B_MUL: begin
                value_next = (amp_prod[25:16] > 10'(jape_pkg::CELL_MAX))
                           ? 8'(jape_pkg::CELL_MAX) : amp_prod[23:16];
                last_next  = (pos_reg == total - jape_pkg::N_W'(1));
                state_next = B_OUT;
            end
            B_OUT: begin
                if (out_ready) begin
                    pos_next = pos_reg + jape_pkg::N_W'(1);
                    if (last_reg) begin
                        state_next = B_IDLE;
                    end else begin
                        state_next = B_START;
                        if (!desc_reg.univ) begin
                            acc_next = acc_reg + desc_reg.b;
                        end else if (col_reg == desc_reg.n - jape_pkg::N_W'(1)) begin
                            col_next = '0;
                            row_next = 1'b1;
                            acc_next = centre0;
                        end else begin
                            col_next = col_reg + jape_pkg::N_W'(1);
                            acc_next = acc_reg + jape_pkg::ACC_W'(jape_pkg::TWOPI_Q12);
                        end
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_ROM) begin
            e_reg <= EXP_ROM[idx_reg];
        end else begin
            e_reg <= e_next;
        end
        desc_reg  <= desc_next;
        acc_reg   <= acc_next;
        pos_reg   <= pos_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        qsq_reg   <= qsq_next;
        idx_reg   <= idx_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/joint_angle_population_encoder_core.sv
// ----------------------------------------------------------------------------
// joint_angle_population_encoder_core
// Encode one joint reading per transfer into a run of Gaussian cell responses.
// ----------------------------------------------------------------------------
// Each input transfer carries one joint reading and produces a run of 8-bit
// cell responses on the output stream, tlast marking the final cell. A linear
// reading (tuser 0) gives n cells spread from range_low to range_high; a
// universal reading (tuser 1) gives two rows of n cells, absolute direction
// then change of direction, scaled by the vector length against the largest
// length seen since reset. The front end resolves a linear item directly and
// a universal one through a 16-step square root and a 9-step divide (the
// divide is skipped when the length is zero), then parks it in a two-entry
// queue, so it takes the next reading while the cell engine is busy. The cell
// engine sets the throughput: a cell whose offset needs the 15-step serial
// divider passes through it, while a cell is sent on without the divider when
// the spread or width factor is zero or the cell is far beyond the spread.
// The exp table is a constant ROM computed at elaboration; no clearing pass
// follows reset.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_angle_population_encoder_core #(
    parameter int unsigned MAX_UNITS       = 16,
    parameter int unsigned EXP_TABLE_DEPTH = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [11:0]  cfg_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // joint_angle, range_low, range_high, delta_x, delta_y, abs_direction,
    // change_direction, zero fill
    input  wire logic [111:0] s_tdata,
    input  wire logic         s_tuser,    // op
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata,    // cell_value, cell_index, zero fill
    output logic              m_tlast     // last
);

    logic [4:0]           units_reg;
    logic [11:0]          width_reg;
    logic                 push, full, pop, empty;
    jape_pkg::jape_desc_t push_data, pop_data;
    logic [7:0]           cell_value;
    logic [4:0]           cell_index;

    // Registers are always writable; accept every transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            units_reg <= 5'd16;
            width_reg <= 12'd256;
        end else if (cfg_valid) begin
            case (cfg_index)
                jape_pkg::REG_UNITS_IN_USE: units_reg <= cfg_data[4:0];
                jape_pkg::REG_WIDTH_FACTOR: width_reg <= cfg_data;
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // Front end: resolve spread, amplitude and cell count.
    jape_front #(
        .MAX_UNITS (MAX_UNITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .units_in_use     (units_reg),
        .width_factor     (width_reg),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .op               (s_tuser),
        .joint_angle      (s_tdata[15:0]),
        .range_low        (s_tdata[31:16]),
        .range_high       (s_tdata[47:32]),
        .delta_x          (s_tdata[63:48]),
        .delta_y          (s_tdata[79:64]),
        .abs_direction    (s_tdata[94:80]),
        .change_direction (s_tdata[109:95]),
        .push             (push),
        .push_data        (push_data),
        .full             (full)
    );

    // Hold resolved items so each side stalls on its own.
    jape_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Cell engine: one response per cell, held in the output register.
    jape_back #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .empty      (empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .cell_value (cell_value),
        .cell_index (cell_index),
        .last       (m_tlast)
    );

    assign m_tdata = {3'b000, cell_index, cell_value};

endmodule

`default_nettype wire

>>> dv/joint_angle_population_encoder_core_test.sv
// ----------------------------------------------------------------------------
// joint_angle_population_encoder_core_test
// Self-checking bench for the joint angle population encoder core.
// ----------------------------------------------------------------------------
// Drive joint readings on the input stream and predict every cell response
// with an independent model of the Gaussian encoder (exp table, square root,
// largest-amplitude register). Results are compared field by field against
// a queue of expected cells. A directed table opens the run, followed by
// random readings under three idling regimes and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module joint_angle_population_encoder_core_test;

    localparam int TABLE_DEPTH = 256;
    localparam int UNIT_CAP    = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] value;
        logic [4:0] index;
        logic       last;
    } cell_t;

    typedef struct {
        logic               univ;
        logic signed [15:0] ang, lo, hi, dx, dy;
        logic signed [14:0] dir_abs, dir_chg;
        int                 fixed_value;   // -1: predictor only
    } reading_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [11:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic         m_tlast;

    joint_angle_population_encoder_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor state
    longint unsigned gauss_rom[TABLE_DEPTH];
    int unsigned     units_reg;
    int unsigned     width_reg;
    longint unsigned peak_ampl;
    cell_t           cells_due[$];
    int              cells_fixed[$];
    int              mismatches = 0;
    int              cycles = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;

    function automatic void build_gauss_rom();
        longint unsigned step, term, e, ratio;
        longint          sum;
        step = (64'd8 << 32) / TABLE_DEPTH;
        term = 64'd1 << 32;
        sum  = longint'(term);
        for (int k = 1; k <= 16; k++) begin
            term = ((term * step) >> 32) / k;
            if (k % 2) sum -= longint'(term); else sum += longint'(term);
        end
        ratio = longint'(sum);
        e = 64'd1 << 32;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            gauss_rom[i] = e >> 16;
            e = (e * ratio) >> 32;
        end
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned tuning(longint unsigned num, longint unsigned den);
        longint unsigned q, idx;
        if (den == 0) return (num == 0) ? 65536 : 0;
        q = (num << 20) / den;
        if (q >= (64'd3 << 12)) return 0;
        idx = ((q * q) * TABLE_DEPTH) >> 27;
        if (idx >= TABLE_DEPTH) return 0;
        return gauss_rom[idx];
    endfunction

    function automatic cell_t make_cell(longint unsigned amp, longint unsigned g, int pos,
                                        int total);
        cell_t c;
        longint unsigned v;
        v = (amp * g) >> 16;
        if (v > 255) v = 255;
        c.value = v[7:0];
        c.index = pos[4:0];
        c.last  = (pos == total - 1);
        return c;
    endfunction

    // Work out the run of cells for one accepted reading and queue it
    task automatic predict_cells(input reading_t r);
        longint n, spread, num, centre, diff, dir, total;
        longint unsigned den, ampl, amp;
        n = units_reg;
        if (n < 2) n = 2;
        if (n > UNIT_CAP) n = UNIT_CAP;
        if (!r.univ) begin
            spread = longint'(r.hi) - longint'(r.lo);
            den = (spread < 0 ? -spread : spread) * width_reg;
            for (int k = 0; k < n; k++) begin
                num = (n - 1) * (longint'(r.lo) - longint'(r.ang)) + k * spread;
                cells_due.push_back(make_cell(256, tuning(num < 0 ? -num : num, den), k, n));
                cells_fixed.push_back(r.fixed_value);
            end
        end else begin
            ampl = root_floor(longint'(r.dx) * r.dx + longint'(r.dy) * r.dy);
            den = longint'(width_reg) * jape_pkg::TWOPI_Q12;
            if (ampl > peak_ampl) peak_ampl = ampl & 17'h1ffff;
            amp = (ampl > 0 && peak_ampl > 0) ? (256 * ampl) / peak_ampl : 0;
            total = 2 * n;
            for (int row = 0; row < 2; row++) begin
                dir = row ? longint'(r.dir_chg) : longint'(r.dir_abs);
                for (int k = 0; k < n; k++) begin
                    centre = longint'(jape_pkg::PI_Q12) * (2 * k + 1 - n);
                    diff = centre - dir * n;
                    if (diff < 0) diff = -diff;
                    if (diff > longint'(jape_pkg::PI_Q12) * n)
                        diff = longint'(jape_pkg::TWOPI_Q12) * n - diff;
                    if (diff < 0) diff = -diff;
                    cells_due.push_back(make_cell(amp, tuning(diff, den), row * n + k,
                                                  total));
                    cells_fixed.push_back(r.fixed_value);
                end
            end
        end
    endtask

    // Send one reading; prediction happens at the accepting edge.
    // Hold tvalid high after a transfer so readings can follow back to back.
    task automatic send_reading(input reading_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.univ;
        s_tdata  <= {1'b0, 1'b0, r.dir_chg, r.dir_abs, r.dy, r.dx, r.hi, r.lo, r.ang};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_cells(r);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == jape_pkg::REG_UNITS_IN_USE) units_reg = val & 12'h1f;
        else width_reg = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain all due cells, then allow the slowest in-flight item to finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (cells_due.size() != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
    endtask

    // Receiver: random stalls, compare each accepted cell with the oldest due one
    always @(posedge aclk) begin
        cell_t got, want;
        int    fixed;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[12:8], m_tlast};
            if (cells_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected cell %h", got);
            end else begin
                want  = cells_due.pop_front();
                fixed = cells_fixed.pop_front();
                if (fixed >= 0) want.value = fixed[7:0];
                if (got !== want || m_tdata[15:13] !== 3'b000) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cell mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.value, want.index, want.last,
                                 got.value, got.index, got.last);
                end
            end
        end
        m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        if (CYCLE_LIMIT > 0) begin
            wait (cycles >= CYCLE_LIMIT);
            $display("joint_angle_population_encoder_core_test: errors");
            $finish;
        end
    end

    function automatic reading_t lin(int ang, int lo, int hi, int fixed);
        reading_t r;
        r = '{default: '0};
        r.univ = 1'b0; r.ang = 16'(ang); r.lo = 16'(lo); r.hi = 16'(hi);
        r.fixed_value = fixed;
        return r;
    endfunction

    function automatic reading_t uni(int dx, int dy, int da, int dc, int fixed);
        reading_t r;
        r = '{default: '0};
        r.univ = 1'b1; r.dx = 16'(dx); r.dy = 16'(dy);
        r.dir_abs = 15'(da); r.dir_chg = 15'(dc);
        r.fixed_value = fixed;
        return r;
    endfunction

    function automatic reading_t random_reading();
        reading_t r;
        int lo, span;
        r = '{default: '0};
        r.fixed_value = -1;
        r.univ = 1'($urandom_range(1));
        r.dx = 16'($urandom); r.dy = 16'($urandom);
        r.dir_abs = 15'($urandom_range(25736) - 12868);
        r.dir_chg = 15'($urandom_range(25736) - 12868);
        if ($urandom_range(9) == 0) begin
            r.dir_abs = 15'($urandom); r.dir_chg = 15'($urandom);
        end
        if ($urandom_range(3) == 0) begin
            r.lo = 16'($urandom); r.hi = 16'($urandom); r.ang = 16'($urandom);
        end else begin
            // mostly a sensible range with the reading inside or near it
            lo = $urandom_range(40000) - 32768;
            span = $urandom_range(32767 - lo);
            r.lo = 16'(lo); r.hi = 16'(lo + span);
            r.ang = 16'(lo + int'($urandom_range(span)));
            if ($urandom_range(1)) begin
                r.lo = 16'(lo + span); r.hi = 16'(lo);
            end
        end
        if ($urandom_range(15) == 0) begin
            r.dx = 16'sd0; r.dy = 16'sd0;
        end
        return r;
    endfunction

    reading_t directed[$];

    initial begin
        build_gauss_rom();
        units_reg = 16; width_reg = 256; peak_ampl = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: zero spread, extremes, zero amplitude, wraps
        directed.push_back(uni(0, 0, 0, 0, 0));                  // zero amplitude: all 0
        directed.push_back(lin(100, 100, 100, -1));              // equal limits
        directed.push_back(lin(0, -32768, 32767, -1));
        directed.push_back(lin(-32768, 32767, -32768, -1));      // reversed limits
        directed.push_back(lin(32767, -32768, 32767, -1));
        directed.push_back(lin(-32768, 0, 4096, 0));             // far from every cell
        directed.push_back(uni(-32768, -32768, -12868, 12868, -1));
        directed.push_back(uni(32767, 32767, 12868, -12868, -1));
        directed.push_back(uni(1, 0, 16383, -16384, -1));        // direction beyond pi
        directed.push_back(uni(4096, -4096, 0, 6434, -1));
        foreach (directed[i]) send_reading(directed[i]);
        settle();

        write_reg(jape_pkg::REG_UNITS_IN_USE, 12'd0);            // below minimum
        write_reg(jape_pkg::REG_WIDTH_FACTOR, 12'd0);            // zero width
        send_reading(lin(500, 500, 500, -1));
        send_reading(lin(0, -4096, 4096, -1));
        send_reading(uni(300, 400, 0, 1000, -1));
        settle();
        write_reg(jape_pkg::REG_UNITS_IN_USE, 12'd31);           // above maximum
        write_reg(jape_pkg::REG_WIDTH_FACTOR, 12'd4095);
        send_reading(lin(1000, -8192, 8192, -1));
        send_reading(uni(-2000, 100, -5000, 7000, -1));
        settle();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 13 : 0;
            write_reg(jape_pkg::REG_UNITS_IN_USE, 12'($urandom_range(31)));
            write_reg(jape_pkg::REG_WIDTH_FACTOR,
                      phase == 2 ? 12'd1 : 12'($urandom_range(4095)));
            for (int i = 0; i < 60; i++) send_reading(random_reading());
            settle();
        end

        if (mismatches == 0 && cells_due.size() == 0) begin
            $display("joint_angle_population_encoder_core_test: clean");
        end else begin
            $display("joint_angle_population_encoder_core_test: errors");
        end
        $finish;
    end

endmodule
